>>> rtl/btb_pkg.sv
// Package with the shared opcodes, widths and control types of the branch target buffer.
package btb_pkg;

    localparam int ADDR_W = 32;
    localparam logic [ADDR_W-1:0] FALL_STEP = 32'd4;

    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_JUMP    = 2'd2,
        OP_SPARE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_MATCH = 2'd1,
        S_WRITE = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic do_match;
        logic do_write;
    } t_ctrl_cmd;

endpackage

>>> rtl/btb_if.sv
// Handshake interfaces for the request and result channels.
interface btb_in_if;
    import btb_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] branch_address;
    logic [ADDR_W-1:0] target_value;
    logic              target_is_relative;
    logic              taken;
    logic              is_jump;

    modport source (output valid, output opcode, output branch_address,
                    output target_value, output target_is_relative, output taken,
                    output is_jump, input ready);
    modport sink (input valid, input opcode, input branch_address,
                  input target_value, input target_is_relative, input taken,
                  input is_jump, output ready);
endinterface

interface btb_out_if;
    import btb_pkg::*;
    logic              valid;
    logic              ready;
    logic              hit;
    logic              predict_taken;
    logic [ADDR_W-1:0] stored_target;
    logic              mispredict;
    logic [ADDR_W-1:0] redirect_pc;

    modport source (output valid, output hit, output predict_taken,
                    output stored_target, output mispredict, output redirect_pc,
                    input ready);
    modport sink (input valid, input hit, input predict_taken,
                  input stored_target, input mispredict, input redirect_pc,
                  output ready);
endinterface

>>> rtl/branch_target_buffer_lru.sv
// A request word is captured at its accepting edge, matched in S_MATCH and written back
// in S_WRITE, where its result word becomes valid.
// The write-back stalls while the previous result word is still unread.
// A new request word is taken only in S_IDLE, after the capture, match and write steps
// of the controller for the previous word; it is taken while the previous result still waits.
// Reset: synchronous active-low reset clears all entry valid bits and the handshake state.
module branch_target_buffer_lru #(
    parameter int ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    btb_in_if.sink    i_in,
    btb_out_if.source o_out
);
    import btb_pkg::*;

    t_ctrl_cmd w_cmd;

    // Sequencing.
    btb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    // Table and result datapath.
    btb_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .i_opcode             (i_in.opcode),
        .i_branch_address     (i_in.branch_address),
        .i_target_value       (i_in.target_value),
        .i_target_is_relative (i_in.target_is_relative),
        .i_taken              (i_in.taken),
        .i_is_jump            (i_in.is_jump),
        .o_hit                (o_out.hit),
        .o_predict_taken      (o_out.predict_taken),
        .o_stored_target      (o_out.stored_target),
        .o_mispredict         (o_out.mispredict),
        .o_redirect_pc        (o_out.redirect_pc)
    );

endmodule

>>> rtl/btb_ctrl.sv
// Controller state machine that sequences capture, match and table write.
module btb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output btb_pkg::t_ctrl_cmd o_cmd
);
    import btb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and result-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands. The write waits until the result register is free.
    // No request word is taken while reset is asserted.
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        n_out_valid    = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.load_in = i_in_valid && i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    n_state = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.do_match = 1'b1;
                n_state        = S_WRITE;
            end
            S_WRITE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.do_write = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/btb_datapath.sv
// Datapath: entry table, parallel tag match, age update, target memory and result register.
module btb_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  btb_pkg::t_ctrl_cmd         i_cmd,
    input  logic [1:0]                 i_opcode,
    input  logic [btb_pkg::ADDR_W-1:0] i_branch_address,
    input  logic [btb_pkg::ADDR_W-1:0] i_target_value,
    input  logic                       i_target_is_relative,
    input  logic                       i_taken,
    input  logic                       i_is_jump,
    output logic                       o_hit,
    output logic                       o_predict_taken,
    output logic [btb_pkg::ADDR_W-1:0] o_stored_target,
    output logic                       o_mispredict,
    output logic [btb_pkg::ADDR_W-1:0] o_redirect_pc
);
    import btb_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [AW-1:0] LRU_AGE = AW'(ENTRIES - 1);

    // Captured request.
    logic [1:0]        r_opcode;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_tval;
    logic              r_rel;
    logic              r_tk;
    logic              r_jmp;

    // Entry table.
    logic [ENTRIES-1:0] r_valid;
    logic [ADDR_W-1:0]  r_key [ENTRIES];
    logic [ENTRIES-1:0] r_taken;
    logic [AW-1:0]      r_age [ENTRIES];
    logic [ADDR_W-1:0]  r_tmem [ENTRIES];
    logic [ADDR_W-1:0]  r_rd_target;

    // Match results.
    logic          r_hit;
    logic          r_pred;
    logic [AW-1:0] r_hit_age;
    logic [AW-1:0] r_widx;

    // Result register.
    logic              r_o_hit;
    logic              r_o_pred;
    logic [ADDR_W-1:0] r_o_stgt;
    logic              r_o_mis;
    logic [ADDR_W-1:0] r_o_redir;

    logic [ENTRIES-1:0] w_match;
    logic               w_hit;
    logic               w_pred;
    logic [AW-1:0]      w_hit_idx;
    logic [AW-1:0]      w_hit_age;
    logic               w_any_free;
    logic [AW-1:0]      w_free_idx;
    logic [AW-1:0]      w_lru_idx;
    logic [AW-1:0]      w_widx;

    logic [ADDR_W-1:0] w_dst;
    logic [ADDR_W-1:0] w_fall;
    logic              w_do_wr;
    logic              w_wtk;
    logic              w_mis;
    logic [ADDR_W-1:0] w_redir;

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_opcode <= i_opcode;
            r_addr   <= i_branch_address;
            r_tval   <= i_target_value;
            r_rel    <= i_target_is_relative;
            r_tk     <= i_taken;
            r_jmp    <= i_is_jump;
        end
    end

    // Parallel tag compare, hit encode, first free slot and oldest slot.
    always_comb begin
        w_hit_idx  = '0;
        w_hit_age  = '0;
        w_lru_idx  = '0;
        w_free_idx = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_match[i] = r_valid[i] && (r_key[i] == r_addr);
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | AW'(i);
                w_hit_age = w_hit_age | r_age[i];
            end
            if (r_valid[i] && (r_age[i] == LRU_AGE)) begin
                w_lru_idx = w_lru_idx | AW'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free_idx = AW'(i);
            end
        end
        w_hit      = |w_match;
        w_pred     = |(w_match & r_taken);
        w_any_free = !(&r_valid);
        w_widx     = w_hit ? w_hit_idx : (w_any_free ? w_free_idx : w_lru_idx);
    end

    // Register the match and read the stored target of the hit slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_match) begin
            r_hit       <= w_hit;
            r_pred      <= w_pred;
            r_hit_age   <= w_hit_age;
            r_widx      <= w_widx;
            r_rd_target <= r_tmem[w_hit_idx];
        end
    end

    // Training decision and redirect address.
    always_comb begin
        w_dst   = r_rel ? (r_addr + r_tval) : r_tval;
        w_fall  = r_addr + FALL_STEP;
        w_do_wr = 1'b0;
        w_wtk   = 1'b0;
        w_mis   = 1'b0;
        case (r_opcode)
            OP_RESOLVE: begin
                w_redir = r_tk ? w_dst : w_fall;
                if (r_tk == r_pred) begin
                    w_do_wr = !r_hit && !r_jmp;
                end else if (r_pred) begin
                    w_mis   = 1'b1;
                    w_do_wr = 1'b1;
                end else begin
                    w_mis   = 1'b1;
                    w_do_wr = !r_jmp;
                    w_wtk   = 1'b1;
                end
            end
            OP_JUMP: begin
                w_redir = w_dst;
                w_do_wr = 1'b1;
                w_wtk   = 1'b1;
            end
            default: begin
                w_redir = r_pred ? w_dst : w_fall;
            end
        endcase
    end

    // Valid bits are the only table state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.do_write && w_do_wr && !r_hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (AW'(i) == r_widx) begin
                    r_valid[i] <= 1'b1;
                end
            end
        end
    end

    // Key, taken bit and age update; the written slot becomes most recent.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && w_do_wr) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (AW'(i) == r_widx) begin
                    r_age[i] <= '0;
                    if (!r_hit) begin
                        r_key[i] <= r_addr;
                    end
                    if (!r_hit || (r_taken[i] != w_wtk)) begin
                        r_taken[i] <= w_wtk;
                    end
                end else if (r_valid[i] && (!r_hit || (r_age[i] < r_hit_age))) begin
                    r_age[i] <= r_age[i] + 1'b1;
                end
            end
        end
    end

    // Target memory write: new entries, or a change of the taken bit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write && w_do_wr && (!r_hit || (r_pred != w_wtk))) begin
            r_tmem[r_widx] <= w_dst;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_write) begin
            r_o_hit   <= r_hit;
            r_o_pred  <= r_pred;
            r_o_stgt  <= r_hit ? r_rd_target : '0;
            r_o_mis   <= w_mis;
            r_o_redir <= w_redir;
        end
    end

    assign o_hit           = r_o_hit;
    assign o_predict_taken = r_o_pred;
    assign o_stored_target = r_o_stgt;
    assign o_mispredict    = r_o_mis;
    assign o_redirect_pc   = r_o_redir;

endmodule
